>>> rtl/dac_pkg.sv
package dac_pkg;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_UNLOCK_HOLD    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DOOR_GRACE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BIO_TIMEOUT    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TAMPER_DEBOUNCE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_REQUIRE_FINGER = 3'd4;

    localparam logic [15:0] UNLOCK_HOLD_RESET     = 16'd5000;
    localparam logic [15:0] DOOR_GRACE_RESET      = 16'd3000;
    localparam logic [15:0] BIO_TIMEOUT_RESET     = 16'd5000;
    localparam logic [15:0] TAMPER_DEBOUNCE_RESET = 16'd50;

    localparam logic [1:0] REMOTE_NONE   = 2'd0;
    localparam logic [1:0] REMOTE_UNLOCK = 2'd1;
    localparam logic [1:0] REMOTE_LOCK   = 2'd2;
    localparam logic [1:0] REMOTE_CLEAR  = 2'd3;

    localparam logic [1:0] EVENT_NONE         = 2'd0;
    localparam logic [1:0] EVENT_GRANT_CARD   = 2'd1;
    localparam logic [1:0] EVENT_GRANT_FINGER = 2'd2;
    localparam logic [1:0] EVENT_DENIED       = 2'd3;

    localparam logic [1:0] ALERT_NONE        = 2'd0;
    localparam logic [1:0] ALERT_AUTH_FAILED = 2'd1;
    localparam logic [1:0] ALERT_DENIED      = 2'd2;
    localparam logic [1:0] ALERT_PROPPED     = 2'd3;

    localparam logic [2:0] DOOR_IDLE    = 3'd0;
    localparam logic [2:0] DOOR_SCAN    = 3'd1;
    localparam logic [2:0] DOOR_BIO     = 3'd2;
    localparam logic [2:0] DOOR_DECIDE  = 3'd3;
    localparam logic [2:0] DOOR_GRANT   = 3'd4;
    localparam logic [2:0] DOOR_DENY    = 3'd5;
    localparam logic [2:0] DOOR_MONITOR = 3'd6;
    localparam logic [2:0] DOOR_RELOCK  = 3'd7;

    typedef struct packed {
        logic [15:0] hold_ms;
        logic [15:0] grace_ms;
        logic [15:0] bio_timeout_ms;
        logic [15:0] debounce_ms;
        logic        require_fingerprint;
    } cfg_t;

    typedef struct packed {
        logic       exit_pressed;
        logic       card_present;
        logic       card_known;
        logic       card_auth_ok;
        logic       finger_match;
        logic       door_open;
        logic       tamper_edge;
        logic [1:0] remote_cmd;
    } in_item_t;

    typedef struct packed {
        logic [2:0] door_state;
        logic       lock_relay;
        logic       status_led;
        logic       lockout_active;
        logic       locked_status;
        logic [1:0] event_code;
        logic       tamper_alert;
        logic [1:0] alert_code;
    } result_t;

endpackage

>>> rtl/dac_in_stage.sv
module dac_in_stage
    import dac_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_elapsed,
    input  in_item_t             s_item,
    input  logic                 advance,
    output logic                 item_valid,
    output in_item_t             item,
    output logic [TIME_BITS-1:0] item_time
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [TIME_BITS-1:0] now_reg;
    logic [TIME_BITS-1:0] now_next;
    in_item_t             item_reg;
    logic [TIME_BITS-1:0] time_reg;
    logic                 take;

    assign s_ready = !valid_reg || advance;
    assign take    = s_valid && s_ready;

    // timestamp depends only on elapsed times, so it is stamped on arrival
    always_comb begin
        now_next   = now_reg + TIME_BITS'(s_elapsed);
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            now_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            if (take) begin
                now_reg <= now_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg <= s_item;
            time_reg <= now_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;
    assign item_time  = time_reg;

endmodule

>>> rtl/dac_step.sv
module dac_step
    import dac_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  in_item_t             item,
    input  logic [TIME_BITS-1:0] item_time,
    input  cfg_t                 cfg,
    output result_t              result_next
);

    typedef enum logic [2:0] {
        ST_IDLE    = DOOR_IDLE,
        ST_SCAN    = DOOR_SCAN,
        ST_BIO     = DOOR_BIO,
        ST_DECIDE  = DOOR_DECIDE,
        ST_GRANT   = DOOR_GRANT,
        ST_DENY    = DOOR_DENY,
        ST_MONITOR = DOOR_MONITOR,
        ST_RELOCK  = DOOR_RELOCK
    } state_t;

    state_t               state_reg, state_next;
    logic [TIME_BITS-1:0] entered_reg, entered_next;
    logic [TIME_BITS-1:0] last_tamper_reg, last_tamper_next;
    logic                 lockout_reg, lockout_next;
    logic                 grant_reg, grant_next;
    logic                 finger_reg, finger_next;
    logic                 relay_reg, relay_next;
    logic                 led_reg, led_next;

    logic [TIME_BITS-1:0] since_tamper;
    logic [TIME_BITS-1:0] since_entered;
    logic [1:0]           event_code;
    logic [1:0]           alert_code;
    logic                 tamper_alert;

    // both differences use pre-pass registers; entered is only read in states
    // that the remote command and tamper handling cannot have just entered
    assign since_tamper  = item_time - last_tamper_reg;
    assign since_entered = item_time - entered_reg;

    always_comb begin
        state_next       = state_reg;
        entered_next     = entered_reg;
        last_tamper_next = last_tamper_reg;
        lockout_next     = lockout_reg;
        grant_next       = grant_reg;
        finger_next      = finger_reg;
        relay_next       = relay_reg;
        led_next         = led_reg;
        event_code       = EVENT_NONE;
        alert_code       = ALERT_NONE;
        tamper_alert     = 1'b0;

        case (item.remote_cmd)
            REMOTE_NONE: begin
            end
            REMOTE_UNLOCK: begin
                if (state_reg == ST_IDLE && !lockout_reg) begin
                    grant_next   = 1'b1;
                    state_next   = ST_GRANT;
                    entered_next = item_time;
                end
            end
            REMOTE_LOCK: begin
                relay_next = 1'b0;
            end
            REMOTE_CLEAR: begin
                lockout_next = 1'b0;
                led_next     = 1'b0;
            end
            default: begin
            end
        endcase

        if (item.tamper_edge && since_tamper > TIME_BITS'(cfg.debounce_ms)) begin
            last_tamper_next = item_time;
            tamper_alert     = 1'b1;
            lockout_next     = 1'b1;
            led_next         = 1'b1;
            relay_next       = 1'b0;
            if (state_next == ST_GRANT || state_next == ST_MONITOR) begin
                state_next   = ST_RELOCK;
                entered_next = item_time;
            end
        end

        case (state_next)
            ST_IDLE: begin
                led_next = lockout_next;
                if (item.exit_pressed) begin
                    grant_next   = 1'b1;
                    state_next   = ST_GRANT;
                    entered_next = item_time;
                end else if (!lockout_next && item.card_present) begin
                    state_next   = ST_SCAN;
                    entered_next = item_time;
                end
            end
            ST_SCAN: begin
                entered_next = item_time;
                if (!(item.card_known && item.card_auth_ok)) begin
                    if (item.card_known) begin
                        alert_code = ALERT_AUTH_FAILED;
                    end
                    state_next = ST_DENY;
                end else if (cfg.require_fingerprint) begin
                    state_next = ST_BIO;
                end else begin
                    grant_next = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_BIO: begin
                if (item.finger_match) begin
                    finger_next  = 1'b1;
                    grant_next   = 1'b1;
                    state_next   = ST_DECIDE;
                    entered_next = item_time;
                end else if (since_entered > TIME_BITS'(cfg.bio_timeout_ms)) begin
                    grant_next   = 1'b0;
                    state_next   = ST_DECIDE;
                    entered_next = item_time;
                end
            end
            ST_DECIDE: begin
                state_next   = grant_next ? ST_GRANT : ST_DENY;
                entered_next = item_time;
            end
            ST_GRANT: begin
                relay_next   = 1'b1;
                event_code   = finger_next ? EVENT_GRANT_FINGER : EVENT_GRANT_CARD;
                state_next   = ST_MONITOR;
                entered_next = item_time;
                finger_next  = 1'b0;
            end
            ST_DENY: begin
                event_code   = EVENT_DENIED;
                alert_code   = ALERT_DENIED;
                state_next   = ST_IDLE;
                entered_next = item_time;
                grant_next   = 1'b0;
                finger_next  = 1'b0;
            end
            ST_MONITOR: begin
                if (since_entered > TIME_BITS'(cfg.hold_ms)) begin
                    relay_next   = 1'b0;
                    state_next   = ST_RELOCK;
                    entered_next = item_time;
                end else if (item.door_open &&
                             since_entered > TIME_BITS'(cfg.grace_ms)) begin
                    alert_code = ALERT_PROPPED;
                end
            end
            ST_RELOCK: begin
                state_next   = ST_IDLE;
                entered_next = item_time;
                grant_next   = 1'b0;
            end
            default: begin
                state_next   = ST_IDLE;
                entered_next = item_time;
                grant_next   = 1'b0;
            end
        endcase

        result_next.door_state     = state_next;
        result_next.lock_relay     = relay_next;
        result_next.status_led     = led_next;
        result_next.lockout_active = lockout_next;
        result_next.locked_status  = (state_next != ST_GRANT) && (state_next != ST_MONITOR);
        result_next.event_code     = event_code;
        result_next.tamper_alert   = tamper_alert;
        result_next.alert_code     = alert_code;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            entered_reg     <= '0;
            last_tamper_reg <= '0;
            lockout_reg     <= 1'b0;
            grant_reg       <= 1'b0;
            finger_reg      <= 1'b0;
            relay_reg       <= 1'b0;
            led_reg         <= 1'b0;
        end else if (fire) begin
            state_reg       <= state_next;
            entered_reg     <= entered_next;
            last_tamper_reg <= last_tamper_next;
            lockout_reg     <= lockout_next;
            grant_reg       <= grant_next;
            finger_reg      <= finger_next;
            relay_reg       <= relay_next;
            led_reg         <= led_next;
        end
    end

endmodule

>>> rtl/dac_out_stage.sv
module dac_out_stage
    import dac_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t result_in,
    output logic    can_load,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign can_load = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result_in;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = data_reg;

endmodule

>>> rtl/door_access_controller.sv
// Door access controller: one transaction on the s_ channel is one controller
// pass (elapsed time plus sampled door, button, card, finger, tamper and remote
// command inputs); each pass returns exactly one result transaction on m_.
// Both channels are valid/ready. Configuration is a write-only port
// (cfg_wr_en, cfg_index, cfg_wdata) and should be written while idle.
// Path: an accepted pass is registered in the input stage, stepped through the
// state machine once the output register can take a result, and loaded into
// the output register, which drives m_valid.
// Throughput: one pass per cycle while m_ready keeps the output register free;
// the input stage frees itself in the same cycle the output register can take
// a result, and the only loop is the state update.
// When m_ready is low the result holds in the output register, the next pass
// waits in the input register, and s_ready drops only once both are full.
// Reset (aresetn low, synchronous): door state idle, strike locked, lockout
// and LED cleared, time counters zero, configuration back to its defaults.
module door_access_controller
    import dac_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_elapsed_ms,
    input  logic                   s_exit_pressed,
    input  logic                   s_card_present,
    input  logic                   s_card_known,
    input  logic                   s_card_auth_ok,
    input  logic                   s_finger_match,
    input  logic                   s_door_open,
    input  logic                   s_tamper_edge,
    input  logic [1:0]             s_remote_cmd,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_door_state,
    output logic                   m_lock_relay,
    output logic                   m_status_led,
    output logic                   m_lockout_active,
    output logic                   m_locked_status,
    output logic [1:0]             m_event_code,
    output logic                   m_tamper_alert,
    output logic [1:0]             m_alert_code
);

    cfg_t                 cfg_reg;
    in_item_t             s_item;
    in_item_t             item;
    logic [TIME_BITS-1:0] item_time;
    logic                 item_valid;
    logic                 out_can_load;
    logic                 fire;
    result_t              result_next;
    result_t              m_result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hold_ms             <= UNLOCK_HOLD_RESET;
            cfg_reg.grace_ms            <= DOOR_GRACE_RESET;
            cfg_reg.bio_timeout_ms      <= BIO_TIMEOUT_RESET;
            cfg_reg.debounce_ms         <= TAMPER_DEBOUNCE_RESET;
            cfg_reg.require_fingerprint <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_UNLOCK_HOLD:     cfg_reg.hold_ms             <= cfg_wdata;
                REG_DOOR_GRACE:      cfg_reg.grace_ms            <= cfg_wdata;
                REG_BIO_TIMEOUT:     cfg_reg.bio_timeout_ms      <= cfg_wdata;
                REG_TAMPER_DEBOUNCE: cfg_reg.debounce_ms         <= cfg_wdata;
                REG_REQUIRE_FINGER:  cfg_reg.require_fingerprint <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign s_item.exit_pressed = s_exit_pressed;
    assign s_item.card_present = s_card_present;
    assign s_item.card_known   = s_card_known;
    assign s_item.card_auth_ok = s_card_auth_ok;
    assign s_item.finger_match = s_finger_match;
    assign s_item.door_open    = s_door_open;
    assign s_item.tamper_edge  = s_tamper_edge;
    assign s_item.remote_cmd   = s_remote_cmd;

    assign fire = item_valid && out_can_load;

    dac_in_stage #(
        .TIME_BITS(TIME_BITS)
    ) u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_elapsed (s_elapsed_ms),
        .s_item    (s_item),
        .advance   (fire),
        .item_valid(item_valid),
        .item      (item),
        .item_time (item_time)
    );

    dac_step #(
        .TIME_BITS(TIME_BITS)
    ) u_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .item       (item),
        .item_time  (item_time),
        .cfg        (cfg_reg),
        .result_next(result_next)
    );

    dac_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .result_in(result_next),
        .can_load (out_can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_door_state     = m_result.door_state;
    assign m_lock_relay     = m_result.lock_relay;
    assign m_status_led     = m_result.status_led;
    assign m_lockout_active = m_result.lockout_active;
    assign m_locked_status  = m_result.locked_status;
    assign m_event_code     = m_result.event_code;
    assign m_tamper_alert   = m_result.tamper_alert;
    assign m_alert_code     = m_result.alert_code;

`ifndef NO_ASSERTIONS
    // an accepted tamper edge always leaves the strike locked under lockout
    a_tamper_locks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tamper_alert |-> m_lockout_active && !m_lock_relay)
        else $error("tamper alert without lockout or with strike energized");

    // a grant event comes out of the grant step: strike energized, now monitoring
    a_grant_monitor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_code == EVENT_GRANT_CARD || m_event_code == EVENT_GRANT_FINGER)
        |-> m_lock_relay && m_door_state == DOOR_MONITOR && !m_locked_status)
        else $error("grant event without energized strike in monitor");

    a_deny_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_code == EVENT_DENIED |-> m_door_state == DOOR_IDLE)
        else $error("deny event not followed by idle");

    a_propped_monitor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_alert_code == ALERT_PROPPED |-> m_door_state == DOOR_MONITOR)
        else $error("propped-open alert outside monitor");
`endif

endmodule

>>> verif/door_access_checker.sv
module door_access_checker
    import dac_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,

    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [7:0]             s_elapsed_ms,
    input  logic                   s_exit_pressed,
    input  logic                   s_card_present,
    input  logic                   s_card_known,
    input  logic                   s_card_auth_ok,
    input  logic                   s_finger_match,
    input  logic                   s_door_open,
    input  logic                   s_tamper_edge,
    input  logic [1:0]             s_remote_cmd,

    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [2:0]             m_door_state,
    input  logic                   m_lock_relay,
    input  logic                   m_status_led,
    input  logic                   m_lockout_active,
    input  logic                   m_locked_status,
    input  logic [1:0]             m_event_code,
    input  logic                   m_tamper_alert,
    input  logic [1:0]             m_alert_code,

    output int                     fail_count,
    output int                     pending,
    output int                     checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow of the controller
    cfg_t                 cfg_m;
    logic [2:0]           door_st;
    logic [TIME_BITS-1:0] now_t, entered_t, tamper_t;
    logic                 lockout_f, grant_f, finger_f, relay_f, led_f;

    result_t              door_q[$];
    int unsigned          err_cnt = 0;
    int unsigned          n_checked = 0;
    result_t              want, got;
    in_item_t             pass_in;

    task automatic reset_shadow();
        cfg_m.hold_ms             = UNLOCK_HOLD_RESET;
        cfg_m.grace_ms            = DOOR_GRACE_RESET;
        cfg_m.bio_timeout_ms      = BIO_TIMEOUT_RESET;
        cfg_m.debounce_ms         = TAMPER_DEBOUNCE_RESET;
        cfg_m.require_fingerprint = 1'b0;
        door_st   = DOOR_IDLE;
        now_t     = '0;
        entered_t = '0;
        tamper_t  = '0;
        lockout_f = 1'b0;
        grant_f   = 1'b0;
        finger_f  = 1'b0;
        relay_f   = 1'b0;
        led_f     = 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_UNLOCK_HOLD:     cfg_m.hold_ms             = d;
            REG_DOOR_GRACE:      cfg_m.grace_ms            = d;
            REG_BIO_TIMEOUT:     cfg_m.bio_timeout_ms      = d;
            REG_TAMPER_DEBOUNCE: cfg_m.debounce_ms         = d;
            REG_REQUIRE_FINGER:  cfg_m.require_fingerprint = d[0];
            default: ;
        endcase
    endtask

    function automatic logic [TIME_BITS-1:0] ms_since(input logic [TIME_BITS-1:0] t);
        return now_t - t;
    endfunction

    task automatic enter(input logic [2:0] s);
        door_st   = s;
        entered_t = now_t;
    endtask

    // one controller pass: remote command, tamper, then one FSM step
    task automatic door_step(input logic [7:0] el, input in_item_t p, output result_t r);
        logic [1:0]           ev, al;
        logic                 ta;
        logic [TIME_BITS-1:0] held;
        ev = EVENT_NONE;
        al = ALERT_NONE;
        ta = 1'b0;
        now_t = now_t + TIME_BITS'(el);

        case (p.remote_cmd)
            REMOTE_UNLOCK: begin
                if (door_st == DOOR_IDLE && !lockout_f) begin
                    grant_f = 1'b1;
                    enter(DOOR_GRANT);
                end
            end
            REMOTE_LOCK: relay_f = 1'b0;
            REMOTE_CLEAR: begin
                lockout_f = 1'b0;
                led_f     = 1'b0;
            end
            default: ;
        endcase

        if (p.tamper_edge && ms_since(tamper_t) > TIME_BITS'(cfg_m.debounce_ms)) begin
            tamper_t  = now_t;
            ta        = 1'b1;
            lockout_f = 1'b1;
            led_f     = 1'b1;
            relay_f   = 1'b0;
            if (door_st == DOOR_GRANT || door_st == DOOR_MONITOR)
                enter(DOOR_RELOCK);
        end

        case (door_st)
            DOOR_IDLE: begin
                led_f = lockout_f;
                if (p.exit_pressed) begin
                    grant_f = 1'b1;
                    enter(DOOR_GRANT);
                end else if (!lockout_f && p.card_present) begin
                    enter(DOOR_SCAN);
                end
            end
            DOOR_SCAN: begin
                if (!(p.card_known && p.card_auth_ok)) begin
                    if (p.card_known)
                        al = ALERT_AUTH_FAILED;
                    enter(DOOR_DENY);
                end else if (cfg_m.require_fingerprint) begin
                    enter(DOOR_BIO);
                end else begin
                    grant_f = 1'b1;
                    enter(DOOR_DECIDE);
                end
            end
            DOOR_BIO: begin
                if (p.finger_match) begin
                    finger_f = 1'b1;
                    grant_f  = 1'b1;
                    enter(DOOR_DECIDE);
                end else if (ms_since(entered_t) > TIME_BITS'(cfg_m.bio_timeout_ms)) begin
                    grant_f = 1'b0;
                    enter(DOOR_DECIDE);
                end
            end
            DOOR_DECIDE: enter(grant_f ? DOOR_GRANT : DOOR_DENY);
            DOOR_GRANT: begin
                relay_f = 1'b1;
                ev = finger_f ? EVENT_GRANT_FINGER : EVENT_GRANT_CARD;
                enter(DOOR_MONITOR);
                finger_f = 1'b0;
            end
            DOOR_DENY: begin
                ev = EVENT_DENIED;
                al = ALERT_DENIED;
                enter(DOOR_IDLE);
                grant_f  = 1'b0;
                finger_f = 1'b0;
            end
            DOOR_MONITOR: begin
                held = ms_since(entered_t);
                if (held > TIME_BITS'(cfg_m.hold_ms)) begin
                    relay_f = 1'b0;
                    enter(DOOR_RELOCK);
                end else if (p.door_open && held > TIME_BITS'(cfg_m.grace_ms)) begin
                    al = ALERT_PROPPED;
                end
            end
            default: begin
                enter(DOOR_IDLE);
                grant_f = 1'b0;
            end
        endcase

        r.door_state     = door_st;
        r.lock_relay     = relay_f;
        r.status_led     = led_f;
        r.lockout_active = lockout_f;
        r.locked_status  = (door_st != DOOR_GRANT && door_st != DOOR_MONITOR);
        r.event_code     = ev;
        r.tamper_alert   = ta;
        r.alert_code     = al;
    endtask

    task automatic cmp_field(input string name, input int unsigned exp_v, input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_shadow();
            door_q.delete();
        end else begin
            if (cfg_wr_en)
                write_reg(cfg_index, cfg_wdata);

            // result side first: a result is registered before it leaves
            if (m_valid && m_ready) begin
                got.door_state     = m_door_state;
                got.lock_relay     = m_lock_relay;
                got.status_led     = m_status_led;
                got.lockout_active = m_lockout_active;
                got.locked_status  = m_locked_status;
                got.event_code     = m_event_code;
                got.tamper_alert   = m_tamper_alert;
                got.alert_code     = m_alert_code;
                if (door_q.size() == 0) begin
                    $error("result transaction with no pass outstanding");
                    err_cnt++;
                end else begin
                    want = door_q.pop_front();
                    n_checked++;
                    cmp_field("door_state", 32'(want.door_state), 32'(got.door_state));
                    cmp_field("lock_relay", 32'(want.lock_relay), 32'(got.lock_relay));
                    cmp_field("status_led", 32'(want.status_led), 32'(got.status_led));
                    cmp_field("lockout_active", 32'(want.lockout_active),
                              32'(got.lockout_active));
                    cmp_field("locked_status", 32'(want.locked_status),
                              32'(got.locked_status));
                    cmp_field("event_code", 32'(want.event_code), 32'(got.event_code));
                    cmp_field("tamper_alert", 32'(want.tamper_alert), 32'(got.tamper_alert));
                    cmp_field("alert_code", 32'(want.alert_code), 32'(got.alert_code));
                end
            end

            if (s_valid && s_ready) begin
                pass_in.exit_pressed = s_exit_pressed;
                pass_in.card_present = s_card_present;
                pass_in.card_known   = s_card_known;
                pass_in.card_auth_ok = s_card_auth_ok;
                pass_in.finger_match = s_finger_match;
                pass_in.door_open    = s_door_open;
                pass_in.tamper_edge  = s_tamper_edge;
                pass_in.remote_cmd   = s_remote_cmd;
                door_step(s_elapsed_ms, pass_in, want);
                door_q.push_back(want);
            end
        end
        pending    <= door_q.size();
        fail_count <= err_cnt;
        checked    <= n_checked;
    end

endmodule

>>> verif/tb.sv
module tb;
    import dac_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIME_BITS    = 32;
    localparam int NUM_SETTINGS = 5;
    localparam int RAND_PASSES  = 80;   // per register setting
    localparam int LONG_HOLD    = 300;  // receiver hold-off, cycles

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;

    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_elapsed_ms = '0;
    logic                   s_exit_pressed = 1'b0;
    logic                   s_card_present = 1'b0;
    logic                   s_card_known = 1'b0;
    logic                   s_card_auth_ok = 1'b0;
    logic                   s_finger_match = 1'b0;
    logic                   s_door_open = 1'b0;
    logic                   s_tamper_edge = 1'b0;
    logic [1:0]             s_remote_cmd = REMOTE_NONE;

    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [2:0]             m_door_state;
    logic                   m_lock_relay;
    logic                   m_status_led;
    logic                   m_lockout_active;
    logic                   m_locked_status;
    logic [1:0]             m_event_code;
    logic                   m_tamper_alert;
    logic [1:0]             m_alert_code;

    int                     fail_count;
    int                     pending;
    int                     checked;

    int                     send_idle_pct = 0;
    int                     recv_idle_pct = 0;
    int                     hold_req = 0;
    int                     hold_seen = 0;
    int                     hold_left = 0;
    int unsigned            n_sent = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    door_access_controller #(.TIME_BITS(TIME_BITS)) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_elapsed_ms     (s_elapsed_ms),
        .s_exit_pressed   (s_exit_pressed),
        .s_card_present   (s_card_present),
        .s_card_known     (s_card_known),
        .s_card_auth_ok   (s_card_auth_ok),
        .s_finger_match   (s_finger_match),
        .s_door_open      (s_door_open),
        .s_tamper_edge    (s_tamper_edge),
        .s_remote_cmd     (s_remote_cmd),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_door_state     (m_door_state),
        .m_lock_relay     (m_lock_relay),
        .m_status_led     (m_status_led),
        .m_lockout_active (m_lockout_active),
        .m_locked_status  (m_locked_status),
        .m_event_code     (m_event_code),
        .m_tamper_alert   (m_tamper_alert),
        .m_alert_code     (m_alert_code)
    );

    door_access_checker #(.TIME_BITS(TIME_BITS)) checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_elapsed_ms     (s_elapsed_ms),
        .s_exit_pressed   (s_exit_pressed),
        .s_card_present   (s_card_present),
        .s_card_known     (s_card_known),
        .s_card_auth_ok   (s_card_auth_ok),
        .s_finger_match   (s_finger_match),
        .s_door_open      (s_door_open),
        .s_tamper_edge    (s_tamper_edge),
        .s_remote_cmd     (s_remote_cmd),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_door_state     (m_door_state),
        .m_lock_relay     (m_lock_relay),
        .m_status_led     (m_status_led),
        .m_lockout_active (m_lockout_active),
        .m_locked_status  (m_locked_status),
        .m_event_code     (m_event_code),
        .m_tamper_alert   (m_tamper_alert),
        .m_alert_code     (m_alert_code),
        .fail_count       (fail_count),
        .pending          (pending),
        .checked          (checked)
    );

    // result-side backpressure, with an occasional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic in_item_t pass_of(input logic ex, input logic cp, input logic ck,
                                         input logic ca, input logic fm, input logic dop,
                                         input logic te, input logic [1:0] rc);
        in_item_t p;
        p.exit_pressed = ex;
        p.card_present = cp;
        p.card_known   = ck;
        p.card_auth_ok = ca;
        p.finger_match = fm;
        p.door_open    = dop;
        p.tamper_edge  = te;
        p.remote_cmd   = rc;
        return p;
    endfunction

    function automatic logic [7:0] rand_elapsed();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // mostly plausible card/finger traffic; the FSM picks out what it samples
    function automatic in_item_t rand_pass();
        logic [1:0] rc;
        case ($urandom_range(19))
            0:       rc = REMOTE_UNLOCK;
            1:       rc = REMOTE_LOCK;
            2, 3:    rc = REMOTE_CLEAR;
            default: rc = REMOTE_NONE;
        endcase
        return pass_of($urandom_range(99) < 8,
                       $urandom_range(99) < 40,
                       $urandom_range(99) < 75,
                       $urandom_range(99) < 75,
                       $urandom_range(99) < 25,
                       $urandom_range(99) < 50,
                       $urandom_range(99) < 6,
                       rc);
    endfunction

    function automatic cfg_t setting_for(input int phase);
        cfg_t c;
        case (phase)
            1: c = '{16'd300, 16'd100, 16'd200, 16'd0, 1'b1};
            2: c = '{16'd0, 16'd0, 16'd0, 16'hFFFF, 1'b1};
            3: c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0};
            default: begin
                c.hold_ms             = 16'($urandom_range(1500));
                c.grace_ms            = 16'($urandom_range(1000));
                c.bio_timeout_ms      = 16'($urandom_range(800));
                c.debounce_ms         = 16'($urandom_range(400));
                c.require_fingerprint = 1'($urandom_range(1));
            end
        endcase
        return c;
    endfunction

    // valid is left high after a transaction; it drops only on an idle cycle or in drain
    task automatic send_pass(input logic [7:0] el, input in_item_t p);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_elapsed_ms   <= el;
        s_exit_pressed <= p.exit_pressed;
        s_card_present <= p.card_present;
        s_card_known   <= p.card_known;
        s_card_auth_ok <= p.card_auth_ok;
        s_finger_match <= p.finger_match;
        s_door_open    <= p.door_open;
        s_tamper_edge  <= p.tamper_edge;
        s_remote_cmd   <= p.remote_cmd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic apply_config(input cfg_t c);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_UNLOCK_HOLD;
        cfg_wdata <= c.hold_ms;
        @(posedge aclk);
        cfg_index <= REG_DOOR_GRACE;
        cfg_wdata <= c.grace_ms;
        @(posedge aclk);
        cfg_index <= REG_BIO_TIMEOUT;
        cfg_wdata <= c.bio_timeout_ms;
        @(posedge aclk);
        cfg_index <= REG_TAMPER_DEBOUNCE;
        cfg_wdata <= c.debounce_ms;
        @(posedge aclk);
        cfg_index <= REG_REQUIRE_FINGER;
        cfg_wdata <= {15'($urandom), c.require_fingerprint};
        @(posedge aclk);
        // unmapped index, must not disturb anything
        cfg_index <= REG_REQUIRE_FINGER + CFG_INDEX_W'($urandom_range(3, 1));
        cfg_wdata <= 16'($urandom);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 31;
        recv_idle_pct = 60;

        // directed corners at reset settings
        send_pass(8'd0,   pass_of(0, 0, 0, 0, 0, 0, 1, REMOTE_NONE));   // tamper at time zero
        send_pass(8'd255, pass_of(1, 0, 0, 0, 0, 0, 0, REMOTE_NONE));   // exit request
        send_pass(8'd0,   pass_of(0, 0, 0, 0, 0, 0, 0, REMOTE_NONE));
        send_pass(8'd255, pass_of(0, 0, 0, 0, 0, 1, 0, REMOTE_LOCK));
        send_pass(8'd255, pass_of(0, 0, 0, 0, 0, 0, 1, REMOTE_NONE));   // tamper in monitor
        send_pass(8'd10,  pass_of(0, 1, 1, 1, 0, 0, 0, REMOTE_NONE));   // card blocked
        send_pass(8'd10,  pass_of(0, 0, 0, 0, 0, 0, 0, REMOTE_UNLOCK)); // unlock blocked
        send_pass(8'd0,   pass_of(1, 0, 0, 0, 0, 0, 0, REMOTE_NONE));   // exit during lockout
        send_pass(8'd255, pass_of(0, 0, 0, 0, 0, 0, 0, REMOTE_CLEAR));
        send_pass(8'd100, pass_of(0, 0, 0, 0, 0, 0, 1, REMOTE_NONE));
        send_pass(8'd1,   pass_of(0, 0, 0, 0, 0, 0, 0, REMOTE_CLEAR));
        send_pass(8'd1,   pass_of(0, 1, 0, 0, 0, 0, 0, REMOTE_NONE));
        send_pass(8'd1,   pass_of(0, 0, 1, 0, 0, 0, 0, REMOTE_NONE));   // known, auth fails
        send_pass(8'd1,   pass_of(0, 0, 0, 0, 0, 0, 0, REMOTE_NONE));
        send_pass(8'd1,   pass_of(0, 1, 0, 0, 0, 0, 0, REMOTE_NONE));
        send_pass(8'd1,   pass_of(0, 0, 0, 1, 0, 0, 0, REMOTE_NONE));   // unknown card
        send_pass(8'd1,   pass_of(0, 0, 0, 0, 0, 0, 0, REMOTE_NONE));
        send_pass(8'd1,   pass_of(0, 1, 0, 0, 0, 0, 0, REMOTE_NONE));
        send_pass(8'd1,   pass_of(0, 0, 1, 1, 0, 0, 0, REMOTE_NONE));   // good card
        send_pass(8'd1,   pass_of(0, 0, 0, 0, 0, 0, 0, REMOTE_UNLOCK));
        send_pass(8'd1,   pass_of(0, 0, 0, 0, 0, 1, 0, REMOTE_UNLOCK)); // grant pass
        send_pass(8'd255, pass_of(1, 1, 1, 1, 1, 1, 1, REMOTE_CLEAR));
        send_pass(8'd200, pass_of(0, 0, 0, 0, 0, 1, 0, REMOTE_NONE));

        for (int phase = 0; phase < NUM_SETTINGS; phase++) begin
            if (phase != 0) begin
                drain();
                apply_config(setting_for(phase));
            end
            if (phase < 2) begin
                send_idle_pct = 31;
                recv_idle_pct = 60;
            end else if (phase < 4) begin
                send_idle_pct = 60;
                recv_idle_pct = 31;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase == 1)
                hold_req++;  // result side stalls; input must back up
            for (int i = 0; i < RAND_PASSES; i++)
                send_pass(rand_elapsed(), rand_pass());
        end

        drain();
        // latency tail: catch any stray result transaction
        repeat (8) @(posedge aclk);

        $display("Summary: %0d passes over %0d register settings, %0d results compared",
                 n_sent, NUM_SETTINGS, checked);
        $display("Covered card, finger, exit, remote and tamper paths with stalls and drains");
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

endmodule
